// ----- hw/rtl/timespec_to_double_bits_top_macros.svh -----
// assertion helpers, expect clk and rst_n in scope
`ifndef TIMESPEC_TO_DOUBLE_BITS_TOP_MACROS_SVH
`define TIMESPEC_TO_DOUBLE_BITS_TOP_MACROS_SVH

// same-cycle implication
`define T2D_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define T2D_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/t2d_pkg.sv -----
package t2d_pkg;

    localparam int SEC_W   = 32;
    localparam int NS_W    = 30;
    localparam int FRAC_W  = 20;
    localparam int FIXED_W = SEC_W + FRAC_W;
    localparam int DBL_W   = 64;
    localparam int MANT_W  = 52;
    localparam int EXP_W   = 11;

    localparam logic [NS_W-1:0] NS_MAX     = 30'd999999999;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

    // floor(2^50 / 1e9): estimate of ns * 2^20 / 1e9, low by at most one
    localparam int                RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP_M    = 21'd1125899;
    localparam int                RECIP_SHIFT = 30;
    localparam int                PROD_W      = NS_W + RECIP_W;

    // remainder stays below 2e9
    localparam int REM_W  = 31;
    localparam int NSLO_W = REM_W - FRAC_W;

    // leading zero search in byte groups
    localparam int GRP_W = 8;
    localparam int GRP_N = (FIXED_W + GRP_W - 1) / GRP_W;
    localparam int PAD_W = GRP_N * GRP_W;
    localparam int GLZ_W = 4;
    localparam int LZ_W  = 6;

    // 1023 + (FIXED_W - 1) - FRAC_W, less the leading zero count
    localparam logic [EXP_W-1:0] EXP_TOP = 11'd1054;

    typedef logic [FIXED_W-1:0] fixed_t;

endpackage

// ----- hw/rtl/t2d_frac.sv -----
module t2d_frac
    import t2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SEC_W-1:0]  seconds,
    input  logic [NS_W-1:0]   nanoseconds,
    output logic              fix_valid,
    input  logic              fix_ready,
    output fixed_t            fix_value
);

    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    logic [SEC_W-1:0]  sec1_reg, sec2_reg;
    logic [NSLO_W-1:0] nslo1_reg, nslo2_reg;
    logic [FRAC_W-1:0] q1_reg, q2_reg;
    logic [REM_W-1:0]  qp2_reg;
    fixed_t            fix3_reg;

    logic [NS_W-1:0]          ns_sat;
    logic [PROD_W-1:0]        prod;
    logic [FRAC_W+NS_W-1:0]   qp_full;
    logic [REM_W-1:0]         rem;
    logic [FRAC_W-1:0]        frac;
    fixed_t                   fix3_next;

    assign en3      = !v3_reg || fix_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 1: saturate and multiply by the reciprocal
    assign ns_sat = (nanoseconds > NS_MAX) ? NS_MAX : nanoseconds;
    assign prod   = PROD_W'(ns_sat) * PROD_W'(RECIP_M);

    // stage 2: back-multiply the estimate
    assign qp_full = (FRAC_W+NS_W)'(q1_reg) * (FRAC_W+NS_W)'(NS_PER_SEC);

    // stage 3: remainder check, only low bits matter since it is below 2e9
    assign rem       = {nslo2_reg, {FRAC_W{1'b0}}} - qp2_reg;
    assign frac      = q2_reg + FRAC_W'(rem >= REM_W'(NS_PER_SEC));
    assign fix3_next = {sec2_reg, frac};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            sec1_reg  <= seconds;
            nslo1_reg <= ns_sat[NSLO_W-1:0];
            q1_reg    <= prod[RECIP_SHIFT+FRAC_W-1:RECIP_SHIFT];
        end
        if (en2 && v1_reg)
        begin
            sec2_reg  <= sec1_reg;
            nslo2_reg <= nslo1_reg;
            q2_reg    <= q1_reg;
            qp2_reg   <= qp_full[REM_W-1:0];
        end
        if (en3 && v2_reg)
            fix3_reg <= fix3_next;
    end

    assign fix_valid = v3_reg;
    assign fix_value = fix3_reg;

endmodule

// ----- hw/rtl/t2d_norm.sv -----
module t2d_norm
    import t2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fix_valid,
    output logic              fix_ready,
    input  fixed_t            fix_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DBL_W-1:0]  double_bits
);

    function automatic logic [GLZ_W-1:0] grp_lz(input logic [GRP_W-1:0] g);
        logic [GLZ_W-1:0] lz;
        lz = GLZ_W'(GRP_W);
        for (int i = 0; i < GRP_W; i++)
        begin
            if (g[i])
                lz = GLZ_W'(GRP_W - 1 - i);
        end
        return lz;
    endfunction

    logic en4, en5, en6;
    logic v4_reg, v5_reg, v6_reg;

    fixed_t             fix4_reg, fix5_reg;
    logic [GLZ_W-1:0]   glz4_reg [GRP_N];
    logic [LZ_W-1:0]    lz5_reg;
    logic               zero5_reg;
    logic [DBL_W-1:0]   dbl6_reg;

    logic [PAD_W-1:0]   pad;
    logic [GLZ_W-1:0]   glz4_next [GRP_N];
    logic [LZ_W-1:0]    lz5_next;
    logic               zero5_next;
    fixed_t             norm;
    logic [MANT_W-1:0]  mant;
    logic [EXP_W-1:0]   expo;
    logic [DBL_W-1:0]   dbl6_next;

    assign en6       = !v6_reg || out_ready;
    assign en5       = !v5_reg || en6;
    assign en4       = !v4_reg || en5;
    assign fix_ready = en4;

    // stage 4: per-group leading zeros, group 0 holds the top bits
    assign pad = {fix_value, {(PAD_W-FIXED_W){1'b0}}};

    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
            glz4_next[g] = grp_lz(pad[PAD_W-1-g*GRP_W -: GRP_W]);
    end

    // stage 5: first nonzero group sets the count
    always_comb
    begin
        lz5_next   = '0;
        zero5_next = 1'b1;
        for (int g = GRP_N - 1; g >= 0; g--)
        begin
            if (glz4_reg[g] != GLZ_W'(GRP_W))
            begin
                lz5_next   = LZ_W'(g * GRP_W) + LZ_W'(glz4_reg[g]);
                zero5_next = 1'b0;
            end
        end
    end

    // stage 6: normalize, hidden one drops off the top
    assign norm      = fix5_reg << lz5_reg;
    assign mant      = MANT_W'({norm[FIXED_W-2:0], 1'b0});
    assign expo      = EXP_TOP - EXP_W'(lz5_reg);
    assign dbl6_next = zero5_reg ? '0 : {1'b0, expo, mant};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en4)
                v4_reg <= fix_valid;
            if (en5)
                v5_reg <= v4_reg;
            if (en6)
                v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4 && fix_valid)
        begin
            fix4_reg <= fix_value;
            for (int g = 0; g < GRP_N; g++)
                glz4_reg[g] <= glz4_next[g];
        end
        if (en5 && v4_reg)
        begin
            fix5_reg  <= fix4_reg;
            lz5_reg   <= lz5_next;
            zero5_reg <= zero5_next;
        end
        if (en6 && v5_reg)
            dbl6_reg <= dbl6_next;
    end

    assign out_valid   = v6_reg;
    assign double_bits = dbl6_reg;

endmodule

// ----- hw/rtl/timespec_to_double_bits_top.sv -----
// Converts a time of unsigned 32-bit seconds plus nanoseconds into the IEEE-754
// binary64 bit pattern of that time in seconds. Nanoseconds above 999999999
// saturate and are truncated to steps of 2^-20 s; zero seconds with a zero
// fraction (under 954 ns) gives +0.0. The block takes one transfer per clock while the
// output is not stalled. Six register stages lie between input and output, and out_valid
// is the valid bit of the last. Three stages form the fraction (reciprocal multiply,
// back-multiply, remainder correction), three normalize it (group leading-zero count,
// count merge, shift and exponent). The last stage is the output register; a stall on
// the output holds each full stage that has no empty stage after it, and earlier
// stages move up into the empty ones.
module timespec_to_double_bits_top
    import t2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [SEC_W-1:0]  seconds,
    input  logic [NS_W-1:0]   nanoseconds,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DBL_W-1:0]  double_bits
);

    logic   f2n_valid;
    logic   f2n_ready;
    fixed_t f2n_fixed;

    logic             f2n_stall;
    logic [EXP_W-1:0] res_exp;
    logic             res_form_ok;

    t2d_frac u_frac (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seconds     (seconds),
        .nanoseconds (nanoseconds),
        .fix_valid   (f2n_valid),
        .fix_ready   (f2n_ready),
        .fix_value   (f2n_fixed)
    );

    t2d_norm u_norm (
        .clk         (clk),
        .rst_n       (rst_n),
        .fix_valid   (f2n_valid),
        .fix_ready   (f2n_ready),
        .fix_value   (f2n_fixed),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .double_bits (double_bits)
    );

    assign f2n_stall = f2n_valid && !f2n_ready;

    // results are positive and either zero or normal within the reachable exponent range
    assign res_exp     = double_bits[DBL_W-2:MANT_W];
    assign res_form_ok = !double_bits[DBL_W-1] &&
                         (double_bits == '0 || (res_exp >= 11'd1003 && res_exp <= EXP_TOP));

`include "timespec_to_double_bits_top_macros.svh"

    // input can only back up when every stage is full and the output is stalled
    `T2D_ASSERT_IMP(a_stall_source, !in_ready, out_valid && !out_ready, "stall not from output")

    // a stalled fixed-point value must hold between the two halves
    `T2D_ASSERT_NEXT(a_mid_hold, f2n_stall, f2n_valid && $stable(f2n_fixed), "mid value lost")

    `T2D_ASSERT_IMP(a_result_form, out_valid, res_form_ok, "malformed result")

endmodule

// ----- tb/timespec_to_double_bits_checker.sv -----
`timescale 1ns / 100ps

module timespec_to_double_bits_checker
    import t2d_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [SEC_W-1:0] seconds,
    input  logic [NS_W-1:0]  nanoseconds,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [DBL_W-1:0] double_bits,
    output int               mismatches,
    output int               expected_left,
    output int               results_checked
);

    localparam logic [63:0] MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;
    localparam int          EXP_BIAS  = 1023;

    logic [DBL_W-1:0] double_expected[$];

    // seconds plus truncated 2^-20 s fraction, as a binary64 pattern
    function automatic logic [DBL_W-1:0] time_to_double(logic [SEC_W-1:0] s,
                                                        logic [NS_W-1:0] ns);
        logic [NS_W-1:0]  ns_sat;
        logic [63:0]      frac;
        logic [63:0]      fix;
        logic [63:0]      mant;
        logic [EXP_W-1:0] expo;
        int               lead;
        int               b;
        ns_sat = (ns > NS_MAX) ? NS_MAX : ns;
        frac = ({34'd0, ns_sat} << 11) / 64'd1953125;
        fix = ({32'd0, s} << FRAC_W) | frac;
        if (fix == 64'd0)
            return '0;
        lead = 0;
        for (b = 0; b < 64; b++)
            if (fix[b])
                lead = b + 1;
        mant = (fix << (53 - lead)) & MANT_MASK;
        expo = EXP_W'(EXP_BIAS + lead - 1 - FRAC_W);
        return {1'b0, expo, mant[MANT_W-1:0]};
    endfunction

    initial
    begin
        mismatches = 0;
        expected_left = 0;
        results_checked = 0;
    end

    always @(posedge clk)
    begin
        logic [DBL_W-1:0] want;
        int               bad;
        bad = 0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (double_expected.size() == 0)
                begin
                    bad = 1;
                    if (mismatches < 10)
                        $display("%0t: result %h with no transfer pending", $realtime,
                                 double_bits);
                end
                else
                begin
                    want = double_expected.pop_front();
                    if (double_bits !== want)
                    begin
                        bad = 1;
                        if (mismatches < 10)
                            $display("%0t: double_bits expected %h got %h", $realtime,
                                     want, double_bits);
                    end
                end
                results_checked <= results_checked + 1;
            end
            if (in_valid && in_ready)
                double_expected.push_back(time_to_double(seconds, nanoseconds));
            mismatches <= mismatches + bad;
            expected_left <= double_expected.size();
        end
    end

endmodule

// ----- tb/timespec_to_double_bits_top_tb.sv -----
`timescale 1ns / 100ps

module timespec_to_double_bits_top_tb;
    import t2d_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 20;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [SEC_W-1:0] seconds;
    logic [NS_W-1:0]  nanoseconds;
    logic             out_valid;
    logic             out_ready;
    logic [DBL_W-1:0] double_bits;

    int mismatches;
    int expected_left;
    int results_checked;
    int items_sent;
    int idle_cycles;

    logic hold_req;
    logic free_rx;

    always #6 clk = ~clk;

    timespec_to_double_bits_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .seconds     (seconds),
        .nanoseconds (nanoseconds),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .double_bits (double_bits)
    );

    timespec_to_double_bits_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .seconds         (seconds),
        .nanoseconds     (nanoseconds),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .double_bits     (double_bits),
        .mismatches      (mismatches),
        .expected_left   (expected_left),
        .results_checked (results_checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [SEC_W-1:0] rand_seconds();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4:          return '0;
            5:          return $urandom_range(0, 15);
            6:          return 32'd1 << $urandom_range(0, 31);
            7:          return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default:    return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [NS_W-1:0] rand_nanoseconds();
        case ($urandom_range(0, 9))
            7:       return NS_W'($urandom_range(0, 2000));
            8:       return NS_W'($urandom);
            9:       return NS_W'($urandom_range(999999000, 30'h3FFF_FFFF));
            default: return NS_W'($urandom_range(0, 999999999));
        endcase
    endfunction

    // offer one item, hold it until the transfer, then idle for the given gap
    task automatic send_time(logic [SEC_W-1:0] s, logic [NS_W-1:0] ns, int gap);
        @(negedge clk);
        in_valid <= 1'b1;
        seconds <= s;
        nanoseconds <= ns;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_empty();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_left != 0)
            @(posedge clk);
    endtask

    task automatic send_random(int count, bit gaps);
        repeat (count)
            send_time(rand_seconds(), rand_nanoseconds(), gaps ? rand_gap() : 0);
    endtask

    // receiver side: random back-pressure, free-running stretches and one long hold
    initial
    begin : receiver
        int low_left;
        low_left = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (low_left > 0)
            begin
                out_ready <= 1'b0;
                low_left--;
            end
            else if (free_rx)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                low_left = rand_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        seconds = '0;
        nanoseconds = '0;
        hold_req = 1'b0;
        free_rx = 1'b0;
        items_sent = 0;
        idle_cycles = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners
        send_time(32'd0, 30'd0, rand_gap());
        send_time(32'd0, 30'd953, rand_gap());         // below one fraction step
        send_time(32'd0, 30'd954, rand_gap());         // smallest nonzero fraction
        send_time(32'd0, 30'd1, 0);
        send_time(32'd0, 30'd1953, 0);
        send_time(32'd0, 30'd488281250, 1);
        send_time(32'd0, 30'd500000000, 0);
        send_time(32'd0, 30'd999999999, 2);
        send_time(32'd0, 30'd1000000000, 0);           // saturates
        send_time(32'd0, 30'h3FFF_FFFF, 0);            // saturates
        send_time(32'd1, 30'd0, 0);
        send_time(32'd1, 30'd500000000, 3);
        send_time(32'd2, 30'd1, 0);
        send_time(32'd7, 30'd999999998, 0);
        send_time(32'd12345, 30'd678901234, 0);
        send_time(32'h0001_0000, 30'd123456789, 1);
        send_time(32'h8000_0000, 30'd0, 0);
        send_time(32'hFFFF_FFFF, 30'd0, 0);
        send_time(32'hFFFF_FFFF, 30'd999999999, 0);
        send_time(32'hFFFF_FFFF, 30'h3FFF_FFFF, 0);
        send_time(32'h5555_5555, 30'h2AAA_AAAA, 0);
        send_time(32'hAAAA_AAAA, 30'h1555_5555, 0);
        wait_empty();

        send_random(150, 1'b1);
        wait_empty();

        // back to back, receiver always ready
        free_rx = 1'b1;
        send_random(100, 1'b0);
        wait_empty();
        free_rx = 1'b0;

        // long output stall while the sender keeps offering
        hold_req = 1'b1;
        send_random(40, 1'b0);
        wait_empty();

        send_random(160, 1'b1);
        wait_empty();

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d times, checked %0d results: corners, saturated nanoseconds,",
                 items_sent, results_checked);
        $display("sub-step zeros, random gaps, free-running flow and a %0d-cycle output stall",
                 LONG_HOLD);
        if (mismatches == 0 && expected_left == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/t2d_pkg.sv
hw/rtl/t2d_frac.sv
hw/rtl/t2d_norm.sv
hw/rtl/timespec_to_double_bits_top.sv
tb/timespec_to_double_bits_checker.sv
tb/timespec_to_double_bits_top_tb.sv
